[rtl/core/fce_pkg.sv]
package fce_pkg;

   // checksum size codes; code 3 behaves as the 32-bit size
   typedef logic [1:0] width_mode_type;
   localparam width_mode_type WIDTH_8  = 2'd0;
   localparam width_mode_type WIDTH_16 = 2'd1;
   localparam width_mode_type WIDTH_32 = 2'd2;

   // configuration register indexes
   typedef enum logic {
      CSR_WIDTH_MODE  = 1'b0,
      CSR_VERIFY_MODE = 1'b1
   } csr_index_type;

   localparam int CSR_DATA_W = 2;

   // byte count saturation point
   localparam logic [2:0] BYTES_SAT = 3'd5;

   // per-cycle control shared by the sum and trailer units
   typedef struct packed {
      logic           advance;
      logic           last;
      logic           verify;
      width_mode_type width;
   } step_type;

endpackage

[rtl/core/fce_req_if.sv]
interface fce_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last;

   modport source (output valid, output data_byte, output last, input ready);
   modport sink (input valid, input data_byte, input last, output ready);
endinterface

[rtl/core/fce_rsp_if.sv]
interface fce_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] checksum;
   logic        verified;

   modport source (output valid, output checksum, output verified, input ready);
   modport sink (input valid, input checksum, input verified, output ready);
endinterface

[rtl/core/fce_sum_unit.sv]
module fce_sum_unit (
   input  logic               clock,
   input  logic               reset,
   input  fce_pkg::step_type  step,
   input  logic               pay_valid,
   input  logic [7:0]         pay_byte,
   output logic [31:0]        checksum
);
   import fce_pkg::*;

   // reduce a 17-bit value modulo 2^k-1 by folding digit groups
   function automatic logic [15:0] mod_fold(input logic [16:0] x, input width_mode_type w);
      logic [5:0]  n_a;
      logic [4:0]  n_b;
      logic [3:0]  n_c;
      logic [8:0]  b_a;
      logic [7:0]  b_b;
      logic [16:0] h_a;
      logic [15:0] h_b;
      logic [15:0] res;
      n_a = 6'(x[3:0]) + 6'(x[7:4]) + 6'(x[11:8]) + 6'(x[15:12]) + 6'(x[16]);
      n_b = 5'(n_a[3:0]) + 5'(n_a[5:4]);
      n_c = n_b[3:0] + 4'(n_b[4]);
      b_a = 9'(x[7:0]) + 9'(x[15:8]) + 9'(x[16]);
      b_b = b_a[7:0] + 8'(b_a[8]);
      h_a = 17'(x[15:0]) + 17'(x[16]);
      h_b = h_a[15:0] + 16'(h_a[16]);
      case (w)
         WIDTH_8:  res = (n_c == 4'hF) ? 16'd0 : 16'(n_c);
         WIDTH_16: res = (b_b == 8'hFF) ? 16'd0 : 16'(b_b);
         default:  res = (h_b == 16'hFFFF) ? 16'd0 : h_b;
      endcase
      return res;
   endfunction

   logic [15:0] first_sum_ff, first_sum_in;
   logic [15:0] second_sum_ff, second_sum_in;
   logic [7:0]  low_byte_ff, low_byte_in;
   logic        pend_ff, pend_in;
   logic        is_wide;
   logic        acc_en;
   logic [15:0] acc_val;
   logic [15:0] s1_new, s2_new;
   logic [31:0] s1_w, s2_w;

   assign is_wide = !(step.width == WIDTH_8 || step.width == WIDTH_16);

   // word pairing and end-of-packet fold of a held low byte
   always_comb begin
      acc_en  = 1'b0;
      acc_val = 16'(pay_byte);
      pend_in = pend_ff;
      low_byte_in = low_byte_ff;
      if (!is_wide) begin
         acc_en = pay_valid;
      end else if (pay_valid && !pend_ff) begin
         pend_in     = 1'b1;
         low_byte_in = pay_byte;
         if (step.last) begin
            acc_en  = 1'b1;
            pend_in = 1'b0;
         end
      end else if (pay_valid) begin
         acc_en  = 1'b1;
         acc_val = {pay_byte, low_byte_ff};
         pend_in = 1'b0;
      end else if (step.last && pend_ff) begin
         acc_en  = 1'b1;
         acc_val = 16'(low_byte_ff);
         pend_in = 1'b0;
      end
   end

   // running sums
   always_comb begin
      s1_new = first_sum_ff;
      s2_new = second_sum_ff;
      if (acc_en) begin
         s1_new = mod_fold(17'(first_sum_ff) + 17'(acc_val), step.width);
         s2_new = mod_fold(17'(second_sum_ff) + 17'(s1_new), step.width);
      end
      first_sum_in  = s1_new;
      second_sum_in = s2_new;
   end

   // packed checksum cut to the current size
   always_comb begin
      s1_w = 32'(s1_new);
      s2_w = 32'(s2_new);
      case (step.width)
         WIDTH_8:  checksum = ((s2_w << 4) | s1_w) & 32'h0000_00FF;
         WIDTH_16: checksum = ((s2_w << 8) | s1_w) & 32'h0000_FFFF;
         default:  checksum = {s2_new, s1_new};
      endcase
   end

   // state update, cleared after the last byte
   always_ff @(posedge clock) begin
      if (reset || (step.advance && step.last)) begin
         first_sum_ff  <= '0;
         second_sum_ff <= '0;
         low_byte_ff   <= '0;
         pend_ff       <= 1'b0;
      end else if (step.advance) begin
         first_sum_ff  <= first_sum_in;
         second_sum_ff <= second_sum_in;
         low_byte_ff   <= low_byte_in;
         pend_ff       <= pend_in;
      end
   end

endmodule

[rtl/core/fce_trailer.sv]
module fce_trailer (
   input  logic               clock,
   input  logic               reset,
   input  fce_pkg::step_type  step,
   input  logic [7:0]         data_byte,
   input  logic [31:0]        checksum,
   output logic               pay_valid,
   output logic [7:0]         pay_byte,
   output logic               verified
);
   import fce_pkg::*;

   logic [7:0]  delay_ff [4];
   logic [2:0]  seen_ff, seen_in;
   logic [2:0]  trail_len;
   logic [31:0] recv;

   // trailer length for the current size
   always_comb begin
      case (step.width)
         WIDTH_8:  trail_len = 3'd1;
         WIDTH_16: trail_len = 3'd2;
         default:  trail_len = 3'd4;
      endcase
   end

   assign seen_in = (seen_ff < BYTES_SAT) ? seen_ff + 3'd1 : seen_ff;

   // byte leaving the delay line, or the raw byte in compute mode
   always_comb begin
      if (!step.verify) begin
         pay_valid = 1'b1;
         pay_byte  = data_byte;
      end else begin
         pay_valid = (seen_ff >= trail_len);
         case (step.width)
            WIDTH_8:  pay_byte = delay_ff[0];
            WIDTH_16: pay_byte = delay_ff[1];
            default:  pay_byte = delay_ff[3];
         endcase
      end
   end

   // received trailer read big-endian, newest byte lowest
   always_comb begin
      case (step.width)
         WIDTH_8:  recv = {24'd0, data_byte};
         WIDTH_16: recv = {16'd0, delay_ff[0], data_byte};
         default:  recv = {delay_ff[2], delay_ff[1], delay_ff[0], data_byte};
      endcase
      verified = step.verify && (seen_in > trail_len) && (recv == checksum);
   end

   // delay line and byte count
   always_ff @(posedge clock) begin
      if (reset || (step.advance && step.last)) begin
         for (int i = 0; i < 4; i++) begin
            delay_ff[i] <= '0;
         end
         seen_ff <= '0;
      end else if (step.advance) begin
         if (step.verify) begin
            delay_ff[0] <= data_byte;
            delay_ff[1] <= delay_ff[0];
            delay_ff[2] <= delay_ff[1];
            delay_ff[3] <= delay_ff[2];
         end
         seen_ff <= seen_in;
      end
   end

endmodule

[rtl/core/fletcher_checksum_engine.sv]
// result: loaded into the result register as its last byte leaves the input register,
// held back only while an earlier result is still waiting to be taken
// throughput: one byte per cycle while no finished result is held back; input register,
// one pass through the modular sum adders, then the result register
// reset: synchronous; 16-bit size, compute mode, sums and delay line cleared
module fletcher_checksum_engine (
   input  logic                                  clock,
   input  logic                                  reset,
   fce_req_if.sink                               req_chan,
   fce_rsp_if.source                             rsp_chan,
   input  logic                                  csr_wr_en,
   input  fce_pkg::csr_index_type                csr_index,
   input  logic [fce_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import fce_pkg::*;

   width_mode_type width_mode_ff;
   logic           verify_mode_ff;
   logic           in_valid_ff;
   logic [7:0]     in_byte_ff;
   logic           in_last_ff;
   logic           rsp_valid_ff;
   logic [31:0]    checksum_ff;
   logic           verified_ff;
   logic           advance;
   logic           load_rsp;
   step_type       step;
   logic           pay_valid;
   logic [7:0]     pay_byte;
   logic [31:0]    checksum;
   logic           verified;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_mode_ff  <= WIDTH_16;
         verify_mode_ff <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_WIDTH_MODE:  width_mode_ff  <= csr_wdata;
            CSR_VERIFY_MODE: verify_mode_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // handshake: an item moves on unless its result has nowhere to go
   assign advance  = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_chan.ready);
   assign load_rsp = advance && in_last_ff;
   assign req_chan.ready = !in_valid_ff || advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.data_byte;
         in_last_ff <= req_chan.last;
      end
   end

   assign step.advance = advance;
   assign step.last    = in_last_ff;
   assign step.verify  = verify_mode_ff;
   assign step.width   = width_mode_ff;

   fce_trailer u_trailer (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .data_byte (in_byte_ff),
      .checksum  (checksum),
      .pay_valid (pay_valid),
      .pay_byte  (pay_byte),
      .verified  (verified)
   );

   fce_sum_unit u_sum (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .pay_valid (pay_valid),
      .pay_byte  (pay_byte),
      .checksum  (checksum)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         checksum_ff <= checksum;
         verified_ff <= verified;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.checksum = checksum_ff;
   assign rsp_chan.verified = verified_ff;

endmodule
